// ----- design/spq_pkg.sv -----
// Shared constants, types and state codes for the sorted priority queue.
`default_nettype none

package spq_pkg;

  // Store size and derived widths
  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  // Fixed field widths
  localparam int unsigned DATA_W = 32;
  localparam int unsigned PRIO_W = 8;
  localparam int unsigned OCC_W  = 5;

  // Request codes
  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  // Data reported when nothing was removed or the queue is empty
  localparam logic signed [DATA_W-1:0] NO_DATA = '1;

  // One stored entry
  typedef struct packed {
    logic [PRIO_W-1:0]        prio;
    logic signed [DATA_W-1:0] data;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Sequencer states
  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_EN_RD  = 7'b0000010,
    S_EN_CMP = 7'b0000100,
    S_EN_PUT = 7'b0001000,
    S_DQ_RD  = 7'b0010000,
    S_DQ_WR  = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_e;

endpackage

`default_nettype wire

// ----- design/sorted_priority_queue.sv -----
// Sorted priority queue: sequencer, entry RAM (one read, one write port) and result register.
// One request in flight: the next is accepted in the cycle after the result is loaded, and a
// stalled result holds the sequencer in its done state.
// Reset clears the count, sequencer and result valid; the entry RAM is not cleared.
`default_nettype none

module sorted_priority_queue (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  // Request channel
  input  wire logic                                   in_valid_i,
  output logic                                        in_stall_o,
  input  wire logic                                   req_type_i,
  input  wire logic signed [spq_pkg::DATA_W-1:0]      item_data_i,
  input  wire logic        [spq_pkg::PRIO_W-1:0]      item_priority_i,
  // Result channel
  output logic                                        out_valid_o,
  input  wire logic                                   out_stall_i,
  output logic signed [spq_pkg::DATA_W-1:0]           dequeued_data_o,
  output logic                                        underflow_o,
  output logic                                        overflow_o,
  output logic signed [spq_pkg::DATA_W-1:0]           head_data_o,
  output logic                                        queue_empty_o,
  output logic        [spq_pkg::OCC_W-1:0]            occupancy_o
);

  spq_pkg::state_e state_q, state_d;

  logic [spq_pkg::CNT_W-1:0]         cnt_q, cnt_d;
  logic [spq_pkg::IDX_W-1:0]         idx_q, idx_d;
  spq_pkg::entry_t                   new_q, new_d;
  logic signed [spq_pkg::DATA_W-1:0] head_q, head_d;
  logic signed [spq_pkg::DATA_W-1:0] deq_q, deq_d;
  logic                              under_q, under_d;
  logic                              over_q, over_d;

  logic                              ram_we;
  logic [spq_pkg::IDX_W-1:0]         ram_waddr;
  logic [spq_pkg::IDX_W-1:0]         ram_raddr;
  spq_pkg::entry_t                   ram_wdata;
  logic [spq_pkg::ENTRY_W-1:0]       ram_rdata;
  spq_pkg::entry_t                   rd_entry;

  logic                              in_acc;
  logic                              out_free;

  assign in_stall_o = (state_q != spq_pkg::S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_o || !out_stall_i;
  assign rd_entry   = spq_pkg::entry_t'(ram_rdata);

  // Entry store
  spq_ram #(
    .Width (spq_pkg::ENTRY_W),
    .Depth (spq_pkg::CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer: walk the store one slot per read/write pair
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    new_d     = new_q;
    head_d    = head_q;
    deq_d     = deq_q;
    under_d   = under_q;
    over_d    = over_q;
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = new_q;
    ram_raddr = idx_q;

    case (state_q)
      spq_pkg::S_IDLE: begin
        if (in_acc) begin
          new_d.data = item_data_i;
          new_d.prio = item_priority_i;
          deq_d      = spq_pkg::NO_DATA;
          under_d    = 1'b0;
          over_d     = 1'b0;
          if (req_type_i == spq_pkg::REQ_ENQ) begin
            if (cnt_q >= spq_pkg::CNT_W'(spq_pkg::CAPACITY)) begin
              // Drop the request on a full store
              over_d  = 1'b1;
              state_d = spq_pkg::S_DONE;
            end else begin
              cnt_d   = cnt_q + spq_pkg::CNT_W'(1);
              idx_d   = spq_pkg::IDX_W'(cnt_q);
              state_d = (cnt_q == '0) ? spq_pkg::S_EN_PUT : spq_pkg::S_EN_RD;
            end
          end else begin
            if (cnt_q == '0) begin
              under_d = 1'b1;
              state_d = spq_pkg::S_DONE;
            end else begin
              deq_d   = head_q;
              cnt_d   = cnt_q - spq_pkg::CNT_W'(1);
              idx_d   = '0;
              state_d = (cnt_q == spq_pkg::CNT_W'(1)) ? spq_pkg::S_DONE
                                                      : spq_pkg::S_DQ_RD;
            end
          end
        end
      end

      spq_pkg::S_EN_RD: begin
        // Fetch the entry just above the free slot
        ram_raddr = idx_q - spq_pkg::IDX_W'(1);
        state_d   = spq_pkg::S_EN_CMP;
      end

      spq_pkg::S_EN_CMP: begin
        ram_we = 1'b1;
        if (rd_entry.prio < new_q.prio) begin
          // Move the lower-priority entry down one slot
          ram_wdata = rd_entry;
          idx_d     = idx_q - spq_pkg::IDX_W'(1);
          state_d   = (idx_q == spq_pkg::IDX_W'(1)) ? spq_pkg::S_EN_PUT
                                                    : spq_pkg::S_EN_RD;
        end else begin
          // Place the new entry behind equal or higher priorities
          ram_wdata = new_q;
          state_d   = spq_pkg::S_DONE;
        end
      end

      spq_pkg::S_EN_PUT: begin
        // Place the new entry at the head
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = new_q;
        head_d    = new_q.data;
        state_d   = spq_pkg::S_DONE;
      end

      spq_pkg::S_DQ_RD: begin
        ram_raddr = idx_q + spq_pkg::IDX_W'(1);
        state_d   = spq_pkg::S_DQ_WR;
      end

      spq_pkg::S_DQ_WR: begin
        // Advance the next entry up one slot
        ram_we    = 1'b1;
        ram_wdata = rd_entry;
        if (idx_q == '0) begin
          head_d = rd_entry.data;
        end
        idx_d   = idx_q + spq_pkg::IDX_W'(1);
        state_d = ((spq_pkg::CNT_W'(idx_q) + spq_pkg::CNT_W'(1)) == cnt_q)
                  ? spq_pkg::S_DONE : spq_pkg::S_DQ_RD;
      end

      spq_pkg::S_DONE: begin
        if (out_free) begin
          state_d = spq_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = spq_pkg::S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spq_pkg::S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Working payload
  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    new_q   <= new_d;
    head_q  <= head_d;
    deq_q   <= deq_d;
    under_q <= under_d;
    over_q  <= over_d;
  end

  // Result valid: set on completion, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (state_q == spq_pkg::S_DONE && out_free) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  // Result payload: hold while stalled
  always_ff @(posedge clk_i) begin
    if (state_q == spq_pkg::S_DONE && out_free) begin
      dequeued_data_o <= deq_q;
      underflow_o     <= under_q;
      overflow_o      <= over_q;
      head_data_o     <= (cnt_q == '0) ? spq_pkg::NO_DATA : head_q;
      queue_empty_o   <= (cnt_q == '0);
      occupancy_o     <= spq_pkg::OCC_W'(cnt_q);
    end
  end

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= spq_pkg::CNT_W'(spq_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_ram_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == spq_pkg::S_EN_CMP || state_q == spq_pkg::S_EN_PUT ||
                state_q == spq_pkg::S_DQ_WR))
    else $error("store written outside a move or place step");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(underflow_o && overflow_o))
    else $error("underflow and overflow reported together");

  a_under_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && underflow_o) |-> (queue_empty_o && occupancy_o == '0))
    else $error("underflow reported on a non-empty queue");

  a_over_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && overflow_o) |->
      (occupancy_o == spq_pkg::OCC_W'(spq_pkg::CAPACITY)))
    else $error("overflow reported on a queue that is not full");

endmodule

`default_nettype wire

// ----- design/spq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module spq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- dv/spq_checker.sv -----
// Checker for the sorted priority queue: mirrors the store, predicts each result and compares.
module spq_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Request channel, observed
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic                                req_type_i,
  input  logic signed [spq_pkg::DATA_W-1:0]   item_data_i,
  input  logic        [spq_pkg::PRIO_W-1:0]   item_priority_i,
  // Result channel, observed
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic signed [spq_pkg::DATA_W-1:0]   dequeued_data_i,
  input  logic                                underflow_i,
  input  logic                                overflow_i,
  input  logic signed [spq_pkg::DATA_W-1:0]   head_data_i,
  input  logic                                queue_empty_i,
  input  logic        [spq_pkg::OCC_W-1:0]    occupancy_i,
  // Status towards the stimulus side
  output int unsigned                         fail_count_o,
  output int unsigned                         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // One result as the block reports it
  typedef struct packed {
    logic signed [spq_pkg::DATA_W-1:0] removed;
    logic                              under;
    logic                              over;
    logic signed [spq_pkg::DATA_W-1:0] head;
    logic                              empty;
    logic [spq_pkg::OCC_W-1:0]         occ;
  } report_t;

  // Mirror of the entry store, head at slot 0
  logic signed [spq_pkg::DATA_W-1:0] mirror_data [spq_pkg::CAPACITY];
  logic        [spq_pkg::PRIO_W-1:0] mirror_prio [spq_pkg::CAPACITY];
  int                                mirror_count;

  // Results still owed by the block, oldest first
  report_t due_reports [$];

  // Apply one request to the mirror and return the result it should produce
  function automatic report_t apply_request(input logic kind,
                                            input logic signed [spq_pkg::DATA_W-1:0] data,
                                            input logic [spq_pkg::PRIO_W-1:0] prio);
    report_t rep;
    int      pos;
    int      i;
    rep.removed = spq_pkg::NO_DATA;
    rep.under   = 1'b0;
    rep.over    = 1'b0;
    if (kind == spq_pkg::REQ_ENQ) begin
      if (mirror_count >= spq_pkg::CAPACITY) begin
        rep.over = 1'b1;
      end else begin
        // Skip every entry of greater or equal priority, then open a gap
        pos = 0;
        while (pos < mirror_count && mirror_prio[pos] >= prio) pos++;
        for (i = mirror_count; i > pos; i--) begin
          mirror_data[i] = mirror_data[i-1];
          mirror_prio[i] = mirror_prio[i-1];
        end
        mirror_data[pos] = data;
        mirror_prio[pos] = prio;
        mirror_count++;
      end
    end else begin
      if (mirror_count == 0) begin
        rep.under = 1'b1;
      end else begin
        // Take the head and close up the store
        rep.removed = mirror_data[0];
        for (i = 0; i + 1 < mirror_count; i++) begin
          mirror_data[i] = mirror_data[i+1];
          mirror_prio[i] = mirror_prio[i+1];
        end
        mirror_count--;
      end
    end
    rep.head  = (mirror_count == 0) ? spq_pkg::NO_DATA : mirror_data[0];
    rep.empty = (mirror_count == 0);
    rep.occ   = spq_pkg::OCC_W'(mirror_count);
    return rep;
  endfunction

  // Predict on each accepted request, compare on each accepted result
  always @(posedge clk_i or negedge rst_ni) begin
    report_t got;
    report_t want;
    if (!rst_ni) begin
      mirror_count = 0;
      due_reports.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        due_reports.push_back(apply_request(req_type_i, item_data_i, item_priority_i));
      end
      if (out_valid_i && !out_stall_i) begin
        got = '{dequeued_data_i, underflow_i, overflow_i, head_data_i, queue_empty_i,
                occupancy_i};
        if (due_reports.size() == 0) begin
          if (fail_count_o < 10) begin
            $display("%0t: unexpected result: removed=%0d under=%0b over=%0b head=%0d",
                     $time, got.removed, got.under, got.over, got.head);
            $display("  empty=%0b occ=%0d", got.empty, got.occ);
          end
          fail_count_o++;
        end else begin
          want = due_reports.pop_front();
          if (got !== want) begin
            if (fail_count_o < 10) begin
              $display("%0t: result mismatch", $time);
              $display("  expected removed=%0d under=%0b over=%0b head=%0d empty=%0b occ=%0d",
                       want.removed, want.under, want.over, want.head, want.empty, want.occ);
              $display("  actual   removed=%0d under=%0b over=%0b head=%0d empty=%0b occ=%0d",
                       got.removed, got.under, got.over, got.head, got.empty, got.occ);
            end
            fail_count_o++;
          end
        end
      end
      pending_o = due_reports.size();
    end
  end

endmodule

// ----- dv/sorted_priority_queue_tb.sv -----
// Testbench top for the sorted priority queue: clock, reset, request traffic and verdict.
module sorted_priority_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic                                clk             = 1'b0;
  logic                                rst_n           = 1'b0;
  logic                                in_valid        = 1'b0;
  logic                                in_stall;
  logic                                req_type        = spq_pkg::REQ_ENQ;
  logic signed [spq_pkg::DATA_W-1:0]   item_data       = '0;
  logic        [spq_pkg::PRIO_W-1:0]   item_priority   = '0;
  logic                                out_valid;
  logic                                out_stall       = 1'b0;
  logic signed [spq_pkg::DATA_W-1:0]   dequeued_data;
  logic                                underflow;
  logic                                overflow;
  logic signed [spq_pkg::DATA_W-1:0]   head_data;
  logic                                queue_empty;
  logic        [spq_pkg::OCC_W-1:0]    occupancy;

  int unsigned failures;
  int unsigned pending;

  // Traffic shaping shared by the sender and the receiver
  int   tx_idle_pct   = 32;
  int   rx_idle_pct   = 52;
  int   traffic_phase = 0;
  logic hold_off      = 1'b0;

  sorted_priority_queue dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .req_type_i      (req_type),
    .item_data_i     (item_data),
    .item_priority_i (item_priority),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .dequeued_data_o (dequeued_data),
    .underflow_o     (underflow),
    .overflow_o      (overflow),
    .head_data_o     (head_data),
    .queue_empty_o   (queue_empty),
    .occupancy_o     (occupancy)
  );

  spq_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .req_type_i      (req_type),
    .item_data_i     (item_data),
    .item_priority_i (item_priority),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .dequeued_data_i (dequeued_data),
    .underflow_i     (underflow),
    .overflow_i      (overflow),
    .head_data_i     (head_data),
    .queue_empty_i   (queue_empty),
    .occupancy_i     (occupancy),
    .fail_count_o    (failures),
    .pending_o       (pending)
  );

  // 4 ns clock
  always #2 clk = ~clk;

  // Stall the result channel at random, or solidly during the hold-off
  always @(negedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < rx_idle_pct);
  end

  // Hold off the receiver for a long stretch so the block backs up its input
  initial begin
    wait (traffic_phase == 2);
    repeat (60) @(negedge clk);
    hold_off <= 1'b1;
    repeat (400) @(negedge clk);
    hold_off <= 1'b0;
  end

  // Abandon a run that hangs
  initial begin
    #4_000_000;
    $display("sorted_priority_queue test failed");
    $finish;
  end

  // Offer one request after an optional gap and hold it until accepted
  task automatic send_req(input logic kind, input logic signed [spq_pkg::DATA_W-1:0] data,
                          input logic [spq_pkg::PRIO_W-1:0] prio);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    req_type      <= kind;
    item_data     <= data;
    item_priority <= prio;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int                                i;
    int                                ph;
    int                                sent;
    int                                burst;
    int                                enq_pct;
    logic                              narrow;
    logic                              kind;
    logic signed [spq_pkg::DATA_W-1:0] data;
    logic        [spq_pkg::PRIO_W-1:0] prio;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Dequeue from empty: underflow
    send_req(spq_pkg::REQ_DEQ, $urandom, spq_pkg::PRIO_W'($urandom));
    // Extremes of data and priority, with ties that must leave in arrival order
    send_req(spq_pkg::REQ_ENQ, 32'sh7FFF_FFFF, 8'd255);
    send_req(spq_pkg::REQ_ENQ, 32'sh8000_0000, 8'd0);
    send_req(spq_pkg::REQ_ENQ, -32'sd1, 8'd255);
    send_req(spq_pkg::REQ_ENQ, 32'sh0, 8'd0);
    send_req(spq_pkg::REQ_ENQ, 32'sh5555_5555, 8'h55);
    send_req(spq_pkg::REQ_ENQ, 32'shAAAA_AAAA, 8'hAA);
    // Fill to capacity, then enqueue into a full queue: overflow
    for (i = 0; i < 10; i++) begin
      send_req(spq_pkg::REQ_ENQ, spq_pkg::DATA_W'(i * 32'h1357_9BDF),
               spq_pkg::PRIO_W'((i % 3) * 127));
    end
    send_req(spq_pkg::REQ_ENQ, 32'sh1234_5678, 8'd200);
    // Drain part of it
    for (i = 0; i < 6; i++) send_req(spq_pkg::REQ_DEQ, $urandom, spq_pkg::PRIO_W'($urandom));

    // Random bursts, each biased towards filling, towards draining, or balanced
    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 32;
          rx_idle_pct = 52;
        end
        1: begin
          tx_idle_pct = 52;
          rx_idle_pct = 32;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      traffic_phase = ph;
      sent = 0;
      while (sent < 433) begin
        case ($urandom_range(2))
          0:       enq_pct = 20;
          1:       enq_pct = 50;
          default: enq_pct = 80;
        endcase
        burst  = $urandom_range(8, 40);
        narrow = 1'($urandom_range(1));
        repeat (burst) begin
          kind = ($urandom_range(99) < enq_pct) ? spq_pkg::REQ_ENQ : spq_pkg::REQ_DEQ;
          data = $urandom;
          if ($urandom_range(9) == 0) data = 32'sh7FFF_FFFF;
          else if ($urandom_range(9) == 0) data = 32'sh8000_0000;
          // Narrow priorities give plenty of ties
          prio = narrow ? spq_pkg::PRIO_W'($urandom_range(3)) : spq_pkg::PRIO_W'($urandom);
          if ($urandom_range(9) == 0) prio = $urandom_range(1) ? 8'hFF : 8'h00;
          send_req(kind, data, prio);
        end
        sent += burst;
      end
    end
    in_valid <= 1'b0;

    // Wait for the last results, then allow for a slow final request
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (failures == 0 && pending == 0) begin
      $display("sorted_priority_queue test passed");
    end else begin
      $display("sorted_priority_queue test failed");
    end
    $finish;
  end

endmodule
